@@ hdl/particle_euler_box_collision_defines.svh @@
// Assertion macros for the particle Euler box collision block.
// Used by the top level only; needs clk and arst_n in scope.
`ifndef PARTICLE_EULER_BOX_COLLISION_DEFINES_SVH
`define PARTICLE_EULER_BOX_COLLISION_DEFINES_SVH
`ifndef SYNTHESIS
`define PEB_ASSERT_NOW(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define PEB_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define PEB_ASSERT_NOW(lbl, a, b)
`define PEB_ASSERT_NEXT(lbl, a, b)
`endif
`endif

@@ hdl/peb_pkg.sv @@
// Shared types, widths, plane codes and saturation for the particle step pipeline.
// No dependencies.
`default_nettype none
package peb_pkg;
	localparam int FB = 16;
	localparam int NW = 32;
	localparam int CB = 16;
	localparam int CW = 17;
	localparam int DTW = 17;
	localparam int DW = NW + 2;
	localparam int SW = 48;
	localparam int PW = NW + DTW + 1;
	localparam int KW = CW + 1;
	localparam logic [KW-1:0] COEF_ONE = KW'(65536);

	typedef logic signed [NW-1:0] num_t;
	typedef logic [2:0][NW-1:0] vec3_t;

	typedef enum logic [2:0] {
		HIT_NONE = 3'd0, HIT_CEIL = 3'd1, HIT_FLOOR = 3'd2, HIT_PX = 3'd3,
		HIT_NX = 3'd4, HIT_PZ = 3'd5, HIT_NZ = 3'd6
	} hit_t;

	typedef enum logic [2:0] {
		REG_ELAST = 3'd0, REG_FRIC = 3'd1, REG_GX = 3'd2, REG_GY = 3'd3,
		REG_GZ = 3'd4, REG_HALFW = 3'd5, REG_HEIGHT = 3'd6
	} reg_t;

	typedef struct packed {
		logic [CW-1:0] elasticity;
		logic [CW-1:0] friction;
		vec3_t grav;
		logic [NW-2:0] half_w;
		logic [NW-2:0] height;
	} cfg_t;

	typedef struct packed {
		logic [DTW-1:0] step_time;
		logic [NW-1:0] life;
		vec3_t vel;
		vec3_t pos;
	} part_t;

	// stepped particle, before the plane test
	typedef struct packed {
		vec3_t p;
		vec3_t v;
		vec3_t p0;
		logic [NW-1:0] life;
		logic alive;
	} step_t;

	typedef struct packed {
		vec3_t p;
		vec3_t v;
		logic [NW-1:0] life;
		logic alive;
		hit_t hit;
		logic [1:0] axis;
		logic neg;
		logic [DW-1:0] dnew;
	} plane_t;

	function automatic num_t sat(input logic signed [SW-1:0] x);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		hi = SW'({1'b0, {(NW-1){1'b1}}});
		lo = -hi - SW'(1);
		if (x > hi) return num_t'(hi);
		if (x < lo) return num_t'(lo);
		return num_t'(x);
	endfunction
endpackage
`default_nettype wire

@@ hdl/peb_step.sv @@
// Euler step: dt products (stage 1), saturated sums and dead bypass (stage 2).
// Depends on peb_pkg.
`default_nettype none
module peb_step (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire peb_pkg::part_t in_part,
	input  wire peb_pkg::cfg_t  cfg,
	output logic               valid_s2,
	output peb_pkg::step_t     st_s2
);
	logic valid_s1;
	peb_pkg::part_t part_s1;
	logic signed [peb_pkg::PW-1:0] pv_s1 [3];
	logic signed [peb_pkg::PW-1:0] gv_s1 [3];
	logic signed [peb_pkg::PW-1:0] pv_c [3];
	logic signed [peb_pkg::PW-1:0] gv_c [3];
	logic signed [peb_pkg::DTW:0] dts;
	peb_pkg::step_t st_c;

	assign dts = $signed({1'b0, in_part.step_time});

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pv_c[i] = dts * $signed(in_part.vel[i]);
			gv_c[i] = dts * $signed(cfg.grav[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			part_s1 <= in_part;
			for (int i = 0; i < 3; i++) begin
				pv_s1[i] <= pv_c[i];
				gv_s1[i] <= gv_c[i];
			end
			st_s2 <= st_c;
		end
	end

	always_comb begin
		logic signed [peb_pkg::SW-1:0] sp;
		logic signed [peb_pkg::SW-1:0] sv;
		logic signed [peb_pkg::SW-1:0] sl;
		st_c.alive = !part_s1.life[peb_pkg::NW-1];
		st_c.p0 = part_s1.pos;
		sl = peb_pkg::SW'($signed(part_s1.life))
			- peb_pkg::SW'($signed({1'b0, part_s1.step_time}));
		st_c.life = st_c.alive ? peb_pkg::sat(sl) : part_s1.life;
		for (int i = 0; i < 3; i++) begin
			sp = peb_pkg::SW'($signed(part_s1.pos[i])) + peb_pkg::SW'(pv_s1[i] >>> peb_pkg::FB);
			sv = peb_pkg::SW'($signed(part_s1.vel[i])) + peb_pkg::SW'(gv_s1[i] >>> peb_pkg::FB);
			// dead particles pass through untouched
			st_c.p[i] = st_c.alive ? peb_pkg::sat(sp) : part_s1.pos[i];
			st_c.v[i] = st_c.alive ? peb_pkg::sat(sv) : part_s1.vel[i];
		end
	end
endmodule
`default_nettype wire

@@ hdl/peb_plane.sv @@
// Plane crossing test in fixed order, first crossing wins (stage 3).
// Depends on peb_pkg.
`default_nettype none
module peb_plane (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire peb_pkg::step_t st,
	input  wire peb_pkg::cfg_t  cfg,
	output logic                valid_s3,
	output peb_pkg::plane_t     pl_s3
);
	peb_pkg::plane_t pl_c;

	always_comb begin
		logic signed [peb_pkg::DW-1:0] dold;
		logic signed [peb_pkg::DW-1:0] dnw;
		logic signed [peb_pkg::DW-1:0] off;
		logic [1:0] ax;
		logic ng;
		logic found;
		found = 1'b0;
		pl_c.p = st.p;
		pl_c.v = st.v;
		pl_c.life = st.life;
		pl_c.alive = st.alive;
		pl_c.hit = peb_pkg::HIT_NONE;
		pl_c.axis = 2'd0;
		pl_c.neg = 1'b0;
		pl_c.dnew = '0;
		for (int i = 0; i < 6; i++) begin
			ax = (i < 2) ? 2'd1 : ((i < 4) ? 2'd0 : 2'd2);
			ng = (i % 2 == 0);
			off = (i == 0) ? peb_pkg::DW'(cfg.height) :
				((i == 1) ? '0 : peb_pkg::DW'(cfg.half_w));
			if (ng) begin
				dold = off - peb_pkg::DW'($signed(st.p0[ax]));
				dnw = off - peb_pkg::DW'($signed(st.p[ax]));
			end else begin
				dold = off + peb_pkg::DW'($signed(st.p0[ax]));
				dnw = off + peb_pkg::DW'($signed(st.p[ax]));
			end
			if (st.alive && !found &&
				((dold > 0 && dnw < 0) || (dold < 0 && dnw > 0))) begin
				found = 1'b1;
				pl_c.hit = peb_pkg::hit_t'(i + 1);
				pl_c.axis = ax;
				pl_c.neg = ng;
				pl_c.dnew = dnw;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s3 <= pl_c;
		end
	end
endmodule
`default_nettype wire

@@ hdl/peb_resp.sv @@
// Collision response: coefficient products (stage 4), reflect and saturate (stage 5).
// Depends on peb_pkg.
`default_nettype none
module peb_resp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire peb_pkg::plane_t pl,
	input  wire peb_pkg::cfg_t   cfg,
	output logic                 valid_s5,
	output peb_pkg::vec3_t       pos_s5,
	output peb_pkg::vec3_t       vel_s5,
	output logic [peb_pkg::NW-1:0] life_s5,
	output logic                 alive_s5,
	output peb_pkg::hit_t        hit_s5
);
	localparam int KDW = peb_pkg::KW + peb_pkg::DW;
	localparam int KVW = peb_pkg::KW + peb_pkg::NW;

	logic valid_s4;
	peb_pkg::plane_t pl_s4;
	logic signed [KDW-1:0] kd_s4;
	logic signed [KVW-1:0] kv_s4;
	logic signed [KVW-1:0] fv_s4 [3];
	logic signed [peb_pkg::KW:0] ks;
	logic signed [peb_pkg::KW:0] fs;
	logic [peb_pkg::KW-1:0] k;

	assign k = peb_pkg::COEF_ONE + peb_pkg::KW'(cfg.elasticity);
	assign ks = $signed({1'b0, k});
	assign fs = $signed({2'b0, cfg.friction});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s4 <= in_valid;
			valid_s5 <= valid_s4;
		end
	end

	// full-width products: operands widen to the register width
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s4 <= pl;
			kd_s4 <= ks * $signed(pl.dnew);
			kv_s4 <= ks * $signed(pl.v[pl.axis]);
			for (int i = 0; i < 3; i++) begin
				fv_s4[i] <= fs * $signed(pl.v[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [peb_pkg::SW-1:0] t;
		logic signed [peb_pkg::SW-1:0] pa;
		peb_pkg::vec3_t pn;
		peb_pkg::vec3_t vn;
		if (en) begin
			pn = pl_s4.p;
			vn = pl_s4.v;
			if (pl_s4.hit != peb_pkg::HIT_NONE) begin
				t = peb_pkg::SW'(kd_s4 >>> peb_pkg::CB);
				pa = peb_pkg::SW'($signed(pl_s4.p[pl_s4.axis]));
				// mirror across the plane: inward normal is negative for ceiling and + walls
				pn[pl_s4.axis] = peb_pkg::sat(pl_s4.neg ? pa + t : pa - t);
				for (int j = 0; j < 3; j++) begin
					if (2'(j) == pl_s4.axis) begin
						vn[j] = peb_pkg::sat(peb_pkg::SW'($signed(pl_s4.v[j]))
							- peb_pkg::SW'(kv_s4 >>> peb_pkg::CB));
					end else begin
						vn[j] = peb_pkg::sat(peb_pkg::SW'($signed(pl_s4.v[j]))
							- peb_pkg::SW'(fv_s4[j] >>> peb_pkg::CB));
					end
				end
			end
			pos_s5 <= pn;
			vel_s5 <= vn;
			life_s5 <= pl_s4.life;
			alive_s5 <= pl_s4.alive;
			hit_s5 <= pl_s4.hit;
		end
	end
endmodule
`default_nettype wire

@@ hdl/particle_euler_box_collision.sv @@
// Particle Euler step with box plane collision, five-stage pipeline.
// Five register stages: s1 and s2 in peb_step, s3 in peb_plane, s4 and s5 in peb_resp.
// Throughput: one particle per cycle; the whole pipeline holds when the output
// register is full and m_axis_tready is low.
// Reset: arst_n clears all valid bits and loads the register defaults
// (e = 1.0, f = 0, g = (0, -9.81, 0), half width 5.0, height 10.0).
`default_nettype none
`include "particle_euler_box_collision_defines.svh"
module particle_euler_box_collision (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life, step_time, zero pad
	input  wire logic [247:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, new_life
	output logic [223:0]      m_axis_tdata,
	// alive, hit_plane
	output logic [3:0]        m_axis_tuser,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	peb_pkg::cfg_t cfg_q;
	peb_pkg::part_t part_in;
	peb_pkg::step_t st_s2;
	peb_pkg::plane_t pl_s3;
	peb_pkg::vec3_t pos_s5;
	peb_pkg::vec3_t vel_s5;
	logic [peb_pkg::NW-1:0] life_s5;
	logic alive_s5;
	peb_pkg::hit_t hit_s5;
	logic valid_s2;
	logic valid_s3;
	logic valid_s5;
	logic en;

	assign en = !valid_s5 || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready = 1'b1;
	assign part_in = peb_pkg::part_t'(s_axis_tdata[240:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.elasticity <= peb_pkg::CW'(65536);
			cfg_q.friction <= '0;
			cfg_q.grav[0] <= '0;
			cfg_q.grav[1] <= peb_pkg::NW'(-642908);
			cfg_q.grav[2] <= '0;
			cfg_q.half_w <= (peb_pkg::NW-1)'(327680);
			cfg_q.height <= (peb_pkg::NW-1)'(655360);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				peb_pkg::REG_ELAST:  cfg_q.elasticity <= cfg_data[peb_pkg::CW-1:0];
				peb_pkg::REG_FRIC:   cfg_q.friction <= cfg_data[peb_pkg::CW-1:0];
				peb_pkg::REG_GX:     cfg_q.grav[0] <= cfg_data;
				peb_pkg::REG_GY:     cfg_q.grav[1] <= cfg_data;
				peb_pkg::REG_GZ:     cfg_q.grav[2] <= cfg_data;
				peb_pkg::REG_HALFW:  cfg_q.half_w <= cfg_data[peb_pkg::NW-2:0];
				peb_pkg::REG_HEIGHT: cfg_q.height <= cfg_data[peb_pkg::NW-2:0];
				default: ;
			endcase
		end
	end

	peb_step u_step (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(s_axis_tvalid),
		.in_part(part_in), .cfg(cfg_q), .valid_s2(valid_s2), .st_s2(st_s2)
	);

	peb_plane u_plane (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(valid_s2),
		.st(st_s2), .cfg(cfg_q), .valid_s3(valid_s3), .pl_s3(pl_s3)
	);

	peb_resp u_resp (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(valid_s3), .pl(pl_s3),
		.cfg(cfg_q), .valid_s5(valid_s5), .pos_s5(pos_s5), .vel_s5(vel_s5),
		.life_s5(life_s5), .alive_s5(alive_s5), .hit_s5(hit_s5)
	);

	assign m_axis_tvalid = valid_s5;
	assign m_axis_tdata = {life_s5, vel_s5, pos_s5};
	assign m_axis_tuser = {hit_s5, alive_s5};

	`PEB_ASSERT_NOW(a_dead_no_hit, valid_s5 && !alive_s5, hit_s5 == peb_pkg::HIT_NONE)
	`PEB_ASSERT_NOW(a_hit_range, valid_s5, hit_s5 != 3'd7)
	`PEB_ASSERT_NEXT(a_stall_holds, valid_s5 && !m_axis_tready, valid_s5 && $stable(m_axis_tdata))
	`PEB_ASSERT_NOW(a_dead_passes_life, valid_s3 && !pl_s3.alive, pl_s3.life[peb_pkg::NW-1])
endmodule
`default_nettype wire
